FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/beroid_pkg.sv
// Shared types and constants for the BER object identifier encoder.
// No dependencies; imported by every module of the block.
package beroid_pkg;

    // Arc and encoding widths
    localparam int ARC_WIDTH      = 31;
    localparam int VAL_W          = ARC_WIDTH + 1;   // room for first*40+second
    localparam int GROUP_W        = 7;
    localparam int MAX_OCTETS     = 5;
    localparam int ENC_W          = GROUP_W * MAX_OCTETS;
    localparam int CNT_W          = $clog2(MAX_OCTETS + 1);
    localparam int FIRST_ARC_MAX  = 2;
    localparam int FIRST_ARC_MULT = 40;
    localparam int Q_DEPTH        = 2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FIRST = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;

    // Input word
    typedef struct packed {
        logic [ARC_WIDTH-1:0] arc;
        logic                 last_arc;
    } arc_word_t;

    // Output word
    typedef struct packed {
        logic [7:0] octet;
        logic       arc_done;
        logic       identifier_done;
        logic [1:0] status;
    } oct_word_t;

    // Job handed from the front end to the octet emitter
    typedef struct packed {
        logic [ENC_W-1:0] value;
        logic [CNT_W-1:0] count;     // octets to emit, 1 to MAX_OCTETS
        logic             last_arc;
        logic [1:0]       status;
    } enc_job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic head_valid;
    } q_stat_t;

endpackage

FILE: rtl/beroid_front.sv
// Front end: accepts arc words, tracks arc position, merges the first two arcs
// and sizes each arc in octets. Depends on beroid_pkg.
module beroid_front
    import beroid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      arc_valid,
    output logic      arc_stall,
    input  arc_word_t arc_word,
    input  q_stat_t   q_stat,
    output logic      push,
    output enc_job_t  job
);

    localparam logic [1:0] POS_FIRST   = 2'd0;
    localparam logic [1:0] POS_SECOND  = 2'd1;
    localparam logic [1:0] POS_LATER   = 2'd2;
    localparam logic [1:0] POS_DISCARD = 2'd3;

    logic [1:0]       pos_reg, pos_next;
    logic [1:0]       held_reg, held_next;
    logic             accept;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] merged;
    logic             over;
    logic [ENC_W-1:0] val_enc;
    logic [CNT_W-1:0] n_oct;
    logic             want_push;

    assign arc_stall = q_stat.full;
    assign accept    = arc_valid && !arc_stall;

    // Merge held first arc into the second arc
    assign base   = (pos_reg == POS_SECOND)
                  ? VAL_W'(held_reg) * VAL_W'(FIRST_ARC_MULT) : '0;
    assign merged = base + VAL_W'(arc_word.arc);

    // Clamp to what five octets hold
    assign over    = (VAL_W > ENC_W) && ((merged >> ENC_W) != '0);
    assign val_enc = over ? '1 : ENC_W'(merged);

    // Octet count from the highest non-zero 7-bit group
    always_comb
    begin
        n_oct = CNT_W'(1);
        for (int g = 1; g < MAX_OCTETS; g++)
        begin
            if ((val_enc >> (GROUP_W * g)) != '0)
            begin
                n_oct = CNT_W'(g + 1);
            end
        end
    end

    // Classify the word
    always_comb
    begin
        pos_next     = pos_reg;
        held_next    = held_reg;
        want_push    = 1'b0;
        job.value    = val_enc;
        job.count    = n_oct;
        job.last_arc = arc_word.last_arc;
        job.status   = ST_OK;
        case (pos_reg)
            POS_FIRST:
            begin
                if (arc_word.arc > ARC_WIDTH'(FIRST_ARC_MAX))
                begin
                    want_push    = 1'b1;
                    job.value    = '0;
                    job.count    = CNT_W'(1);
                    job.last_arc = 1'b1;
                    job.status   = ST_BAD_FIRST;
                    pos_next     = arc_word.last_arc ? POS_FIRST : POS_DISCARD;
                end
                else if (arc_word.last_arc)
                begin
                    held_next    = arc_word.arc[1:0];
                    want_push    = 1'b1;
                    job.value    = '0;
                    job.count    = CNT_W'(1);
                    job.last_arc = 1'b1;
                    job.status   = ST_SHORT;
                    pos_next     = POS_FIRST;
                end
                else
                begin
                    held_next = arc_word.arc[1:0];
                    pos_next  = POS_SECOND;
                end
            end
            POS_SECOND, POS_LATER:
            begin
                want_push = 1'b1;
                pos_next  = arc_word.last_arc ? POS_FIRST : POS_LATER;
            end
            default:
            begin
                pos_next = arc_word.last_arc ? POS_FIRST : POS_DISCARD;
            end
        endcase
    end

    assign push = accept && want_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_FIRST;
            held_reg <= 2'd0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

endmodule

FILE: rtl/beroid_queue.sv
// Short job queue between the front end and the octet emitter.
// Register based FIFO; depends on beroid_pkg for the job type.
module beroid_queue
    import beroid_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  enc_job_t push_job,
    input  logic     pop,
    output enc_job_t head_job,
    output q_stat_t  q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    enc_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign q_stat.full       = (cnt_reg == CW'(DEPTH));
    assign q_stat.head_valid = (cnt_reg != '0);
    assign head_job          = slot_reg[rd_reg];

    // Pointer and count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/beroid_back.sv
// Octet emitter: walks the head job one base-128 group per cycle into the
// output register while that register is free or not stalled. Depends on beroid_pkg.
module beroid_back
    import beroid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  enc_job_t  head_job,
    input  q_stat_t   q_stat,
    output logic      pop,
    output logic      oct_valid,
    input  logic      oct_stall,
    output oct_word_t oct_word
);

    logic [CNT_W-1:0]   step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    oct_word_t          out_word_reg, out_word_next;
    logic               can_load;
    logic               emit;
    logic               final_oct;
    logic [CNT_W-1:0]   grp_idx;
    logic [GROUP_W-1:0] grp;

    assign can_load  = !out_valid_reg || !oct_stall;
    assign emit      = q_stat.head_valid && can_load;
    assign final_oct = (step_reg == head_job.count - CNT_W'(1));
    assign grp_idx   = head_job.count - CNT_W'(1) - step_reg;
    assign pop       = emit && final_oct;

    // Group select, most significant first
    always_comb
    begin
        grp = '0;
        for (int g = 0; g < MAX_OCTETS; g++)
        begin
            if (grp_idx == CNT_W'(g))
            begin
                grp = head_job.value[GROUP_W*g +: GROUP_W];
            end
        end
    end

    // Next output word and step
    always_comb
    begin
        step_next                     = step_reg;
        out_valid_next                = out_valid_reg && oct_stall;
        out_word_next                 = out_word_reg;
        if (emit)
        begin
            out_valid_next                = 1'b1;
            out_word_next.octet           = {!final_oct, grp};
            out_word_next.arc_done        = final_oct;
            out_word_next.identifier_done = final_oct && head_job.last_arc;
            out_word_next.status          = head_job.status;
            step_next = final_oct ? '0 : step_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign oct_valid = out_valid_reg;
    assign oct_word  = out_word_reg;

endmodule

FILE: rtl/ber_object_identifier_encoder.sv
// BER object identifier content encoder. One arc word in, base-128 content
// octets out, one octet per cycle while oct_stall is low. The front end
// takes an arc word every cycle while its two-entry job queue has room; the
// first arc is held and gives no octet, and arcs after a bad first arc are
// dropped without output. Each encoded arc then gives 1 to 5 octets and an
// error word a single octet. The emitter's single output register sets the
// sustained rate, so throughput is one octet per cycle when not stalled. An
// accepted arc word goes into the job queue, then its first octet through the
// emitter's output register. Depends on beroid_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ber_object_identifier_encoder
    import beroid_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      arc_valid,
    output logic      arc_stall,
    input  arc_word_t arc_word,
    output logic      oct_valid,
    input  logic      oct_stall,
    output oct_word_t oct_word
);

    logic     push;
    logic     pop;
    enc_job_t push_job;
    enc_job_t head_job;
    q_stat_t  q_stat;

    beroid_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .arc_valid (arc_valid),
        .arc_stall (arc_stall),
        .arc_word  (arc_word),
        .q_stat    (q_stat),
        .push      (push),
        .job       (push_job)
    );

    beroid_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    beroid_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .pop       (pop),
        .oct_valid (oct_valid),
        .oct_stall (oct_stall),
        .oct_word  (oct_word)
    );

    // Error words are single zero octets that close the identifier
    `ASSERT_IMPLY(a_err_word, oct_valid && (oct_word.status != ST_OK), (oct_word.octet == 8'd0) && oct_word.arc_done && oct_word.identifier_done)
    // Identifier end only on an arc end
    `ASSERT_IMPLY(a_id_on_arc, oct_valid && oct_word.identifier_done, oct_word.arc_done)
    // Continuation flag matches the arc-end flag
    `ASSERT_IMPLY(a_cont_bit, oct_valid, oct_word.octet[7] == !oct_word.arc_done)
    // Octets of one arc follow without gaps
    `ASSERT_NEXT(a_no_gap, oct_valid && !oct_stall && !oct_word.arc_done, oct_valid)

endmodule
